FILE: hw/rtl/lbi_pkg.sv
// Shared types and constants of the level bracket interpolator.
// Depends on nothing; every other file of the block but the two channel interfaces imports it.
package lbi_pkg;

  // Field widths fixed by the item formats.
  localparam int HEIGHT_W = 24;
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int ENTRY_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int LEVEL_W  = 8;
  localparam int WEIGHT_W = 17;

  // Q16 one, the weight of a clamped result.
  localparam logic [WEIGHT_W-1:0] Q_ONE = 17'h10000;

  // Reset value of the level count register.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd150;

  // Operation codes of an input beat.
  localparam logic [OP_W-1:0] OP_LOAD_HEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_VALUE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic                       we_height;
    logic                       we_value;
    logic [ENTRY_W-1:0]         index;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [VALUE_W-1:0]  value;
  } load_t;

  // Query token that walks down the row of cells.
  typedef struct packed {
    logic                       valid;
    logic                       found;
    logic                       clamp;
    logic signed [HEIGHT_W-1:0] target;
    logic signed [HEIGHT_W-1:0] up_height;
    logic signed [VALUE_W-1:0]  up_value;
    logic signed [HEIGHT_W-1:0] lo_height;
    logic signed [VALUE_W-1:0]  lo_value;
  } tok_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  // Sequencer controls.
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic div_start;
    logic out_load;
  } ctl_t;

endpackage

FILE: hw/rtl/lbi_in_if.sv
// Input channel of the level bracket interpolator: valid, ready and one item.
// Depends on nothing.
interface lbi_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [7:0]        entry_index;
  logic signed [23:0] entry_height;
  logic signed [31:0] entry_value;
  logic signed [23:0] target_height;

  modport source (output valid, op, entry_index, entry_height, entry_value, target_height,
                  input ready);
  modport sink (input valid, op, entry_index, entry_height, entry_value, target_height,
                output ready);
endinterface

FILE: hw/rtl/lbi_out_if.sv
// Result channel of the level bracket interpolator: valid, ready and one result.
// Depends on nothing.
interface lbi_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         upper_level;
  logic [7:0]         lower_level;
  logic [16:0]        weight;
  logic signed [31:0] result_value;
  logic               clamped;

  modport source (output valid, upper_level, lower_level, weight, result_value, clamped,
                  input ready);
  modport sink (input valid, upper_level, lower_level, weight, result_value, clamped,
                output ready);
endinterface

FILE: hw/rtl/lbi_cell.sv
// One table cell: holds one level height and one sample value and updates the
// passing query token. Depends on lbi_pkg.
module lbi_cell #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lbi_pkg::load_t  load,
  input  logic [IDX_W-1:0] last_idx,
  input  lbi_pkg::tok_t   tok_in,
  input  logic [IDX_W-1:0] up_in,
  input  logic [IDX_W-1:0] lo_in,
  output lbi_pkg::tok_t   tok_out,
  output logic [IDX_W-1:0] up_out,
  output logic [IDX_W-1:0] lo_out
);
  import lbi_pkg::*;

  localparam int CMP_W = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [HEIGHT_W-1:0] height_r;
  logic signed [VALUE_W-1:0]  value_r;
  logic                       valid_r;
  tok_t                       tok_r;
  tok_t                       tok_nxt;
  logic [IDX_W-1:0]           up_r, up_nxt;
  logic [IDX_W-1:0]           lo_r, lo_nxt;
  logic [CMP_W-1:0]           wr_idx;
  logic                       hit;
  logic                       is_last;

  // Table write: the cell whose index matches takes the beat.
  assign wr_idx  = CMP_W'(load.index);
  assign hit     = (wr_idx == CMP_W'(CELL_IDX));
  assign is_last = (last_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (load.we_height && hit) begin
      height_r <= load.height;
    end
    if (load.we_value && hit) begin
      value_r <= load.value;
    end
  end

  // Token update: take the first level below the target as lower, keep the
  // one before it as upper; the first and last cells add the clamp tests.
  always_comb begin
    tok_nxt = tok_in;
    up_nxt  = up_in;
    lo_nxt  = lo_in;
    if (tok_in.valid) begin
      if (!tok_in.found) begin
        if ((CELL_IDX == 0) && (tok_in.target >= height_r)) begin
          tok_nxt.found     = 1'b1;
          tok_nxt.clamp     = 1'b1;
          up_nxt            = MY_IDX;
          lo_nxt            = MY_IDX;
          tok_nxt.up_height = height_r;
          tok_nxt.up_value  = value_r;
          tok_nxt.lo_height = height_r;
          tok_nxt.lo_value  = value_r;
        end else if (height_r < tok_in.target) begin
          tok_nxt.found     = 1'b1;
          lo_nxt            = MY_IDX;
          tok_nxt.lo_height = height_r;
          tok_nxt.lo_value  = value_r;
        end else begin
          up_nxt            = MY_IDX;
          tok_nxt.up_height = height_r;
          tok_nxt.up_value  = value_r;
        end
      end
      // A target at or below the last level wins over everything else.
      if (is_last && (tok_in.target <= height_r)) begin
        tok_nxt.found     = 1'b1;
        tok_nxt.clamp     = 1'b1;
        up_nxt            = MY_IDX;
        lo_nxt            = MY_IDX;
        tok_nxt.up_height = height_r;
        tok_nxt.up_value  = value_r;
        tok_nxt.lo_height = height_r;
        tok_nxt.lo_value  = value_r;
      end
    end
  end

  // Token registers: only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tok_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    up_r  <= up_nxt;
    lo_r  <= lo_nxt;
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = valid_r;
  end

  assign up_out = up_r;
  assign lo_out = lo_r;

endmodule

FILE: hw/rtl/lbi_div.sv
// Restoring divider for the Q16 weight: one quotient bit per cycle.
// Depends on lbi_pkg.
module lbi_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lbi_pkg::HEIGHT_W-1:0]     num,
  input  logic [lbi_pkg::HEIGHT_W-1:0]     den,
  output logic                             done,
  output logic [lbi_pkg::WEIGHT_W-1:0]     quot
);
  import lbi_pkg::*;

  localparam int CNT_W = $clog2(WEIGHT_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [HEIGHT_W:0]     rem_r, rem_nxt;
  logic [HEIGHT_W-1:0]   den_r;
  logic [WEIGHT_W-1:0]   quot_r;
  logic                  ge;
  logic [HEIGHT_W:0]     diff;

  // One step: compare, subtract, shift. The remainder stays below the divisor,
  // and num never exceeds den, so the quotient fits in WEIGHT_W bits.
  always_comb begin
    ge      = (rem_r >= {1'b0, den_r});
    diff    = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt = {diff[HEIGHT_W-1:0], 1'b0};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WEIGHT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[WEIGHT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: hw/rtl/level_bracket_interpolator_top.sv
// Level bracket interpolator: a table of MAX_LEVELS cells, one level height
// and one sample value each, written by load beats that give no result. A
// query beat sends a token down the row of cells, one cell a cycle, through
// all MAX_LEVELS cells whatever the level count; a bracketed query then goes
// through the bit-serial weight divider and then the interpolation multiply
// and the output register, while a clamped query skips the divider. One beat
// is in work at a time; the output register holds a finished result while the
// next beat is taken. Depends on lbi_pkg, lbi_in_if, lbi_out_if, lbi_cell and
// lbi_div.
module level_bracket_interpolator_top #(
  parameter int MAX_LEVELS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lbi_pkg::COUNT_W-1:0]  cfg_wdata,
  lbi_in_if.sink                       in_ch,
  lbi_out_if.source                    out_ch
);
  import lbi_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEVELS);
  localparam int EXT_W = (IDX_W > LEVEL_W) ? IDX_W : LEVEL_W;

  state_t                     state_r, state_nxt;
  ctl_t                       ctl;
  logic [COUNT_W-1:0]         level_count_r;
  logic [10:0]                cnt_ext;
  logic [IDX_W-1:0]           last_idx;
  logic                       in_acc;
  load_t                      load;
  tok_t                       tok_head;
  tok_t                       tok_chain [MAX_LEVELS+1];
  logic [IDX_W-1:0]           up_chain  [MAX_LEVELS+1];
  logic [IDX_W-1:0]           lo_chain  [MAX_LEVELS+1];
  tok_t                       tail;
  logic signed [HEIGHT_W:0]   num_w, den_w;
  logic                       div_done;
  logic [WEIGHT_W-1:0]        div_quot;
  logic [IDX_W-1:0]           up_idx_r, lo_idx_r;
  logic                       clamp_r;
  logic signed [VALUE_W-1:0]  v_up_r, v_lo_r;
  logic [WEIGHT_W-1:0]        weight_r;
  logic signed [VALUE_W:0]    delta;
  logic signed [WEIGHT_W+VALUE_W+1:0] prod_nxt, prod_r;
  logic signed [VALUE_W-1:0]  result_nxt;
  logic [EXT_W-1:0]           up_ext, lo_ext;
  logic                       out_valid_r;
  logic [LEVEL_W-1:0]         out_up_r, out_lo_r;
  logic [WEIGHT_W-1:0]        out_weight_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic                       out_clamp_r;

  // Level count register and the index of the last level in use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      level_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    cnt_ext = 11'(level_count_r);
    if (cnt_ext == 11'd0) begin
      last_idx = '0;
    end else if (cnt_ext > 11'(MAX_LEVELS)) begin
      last_idx = IDX_W'(MAX_LEVELS - 1);
    end else begin
      last_idx = IDX_W'(cnt_ext - 11'd1);
    end
  end

  // Input beat decode.
  assign in_ch.ready     = ctl.in_ready;
  assign in_acc          = in_ch.valid && ctl.in_ready;
  assign load.we_height  = in_acc && (in_ch.op == OP_LOAD_HEIGHT);
  assign load.we_value   = in_acc && (in_ch.op == OP_LOAD_VALUE);
  assign load.index      = in_ch.entry_index;
  assign load.height     = in_ch.entry_height;
  assign load.value      = in_ch.entry_value;

  // Token injected at the head of the row.
  always_comb begin
    tok_head        = '0;
    tok_head.valid  = in_acc && (in_ch.op == OP_QUERY);
    tok_head.target = in_ch.target_height;
  end

  assign tok_chain[0] = tok_head;
  assign up_chain[0]  = '0;
  assign lo_chain[0]  = '0;

  // Row of table cells.
  for (genvar gi = 0; gi < MAX_LEVELS; gi++) begin : g_cell
    lbi_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (gi)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (load),
      .last_idx (last_idx),
      .tok_in   (tok_chain[gi]),
      .up_in    (up_chain[gi]),
      .lo_in    (lo_chain[gi]),
      .tok_out  (tok_chain[gi+1]),
      .up_out   (up_chain[gi+1]),
      .lo_out   (lo_chain[gi+1])
    );
  end

  assign tail = tok_chain[MAX_LEVELS];

  // Divider operands from the token leaving the row; both are positive.
  assign num_w = {tail.target[HEIGHT_W-1], tail.target}
               - {tail.lo_height[HEIGHT_W-1], tail.lo_height};
  assign den_w = {tail.up_height[HEIGHT_W-1], tail.up_height}
               - {tail.lo_height[HEIGHT_W-1], tail.lo_height};

  lbi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (num_w[HEIGHT_W-1:0]),
    .den   (den_w[HEIGHT_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.op == OP_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          state_nxt = tail.clamp ? ST_MUL : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
      end
      ST_SCAN: begin
        ctl.capture   = tail.valid;
        ctl.div_start = tail.valid && !tail.clamp;
      end
      ST_DIV: begin
      end
      ST_MUL: begin
      end
      ST_OUT: begin
        ctl.out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Bracket capture, weight and product registers.
  assign delta    = {v_up_r[VALUE_W-1], v_up_r} - {v_lo_r[VALUE_W-1], v_lo_r};
  assign prod_nxt = $signed({1'b0, weight_r}) * delta;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      up_idx_r <= up_chain[MAX_LEVELS];
      lo_idx_r <= lo_chain[MAX_LEVELS];
      clamp_r  <= tail.clamp;
      v_up_r   <= tail.up_value;
      v_lo_r   <= tail.lo_value;
      weight_r <= Q_ONE;
    end else if (div_done) begin
      weight_r <= div_quot;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
  end

  // Interpolated value: lower + floor(weight * (upper - lower) / 65536).
  assign result_nxt = v_lo_r + prod_r[VALUE_W+15:16];
  assign up_ext     = EXT_W'(up_idx_r);
  assign lo_ext     = EXT_W'(lo_idx_r);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_up_r     <= up_ext[LEVEL_W-1:0];
      out_lo_r     <= lo_ext[LEVEL_W-1:0];
      out_weight_r <= weight_r;
      out_value_r  <= result_nxt;
      out_clamp_r  <= clamp_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.upper_level  = out_up_r;
  assign out_ch.lower_level  = out_lo_r;
  assign out_ch.weight       = out_weight_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.clamped      = out_clamp_r;

endmodule

FILE: test/level_bracket_interpolator_checker.sv
// Checker of the level bracket interpolator: watches the load, query and result
// channels, predicts each interpolation and compares it field by field.
// Depends on lbi_pkg, lbi_in_if and lbi_out_if.
`timescale 1ns / 100ps

module level_bracket_interpolator_checker #(
  parameter int MAX_LEVELS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lbi_pkg::COUNT_W-1:0]  cfg_wdata,
  lbi_in_if                            in_ch,
  lbi_out_if                           out_ch,
  output int                           failure_count,
  output int                           pending_results,
  output int                           results_checked
);
  import lbi_pkg::*;

  localparam longint WEIGHT_ONE = Q_ONE;

  // One predicted interpolation result.
  typedef struct packed {
    logic [LEVEL_W-1:0]        upper;
    logic [LEVEL_W-1:0]        lower;
    logic [WEIGHT_W-1:0]       weight;
    logic signed [VALUE_W-1:0] value;
    logic                      clamped;
  } interp_t;

  // Shadow copy of the level table and the level count register.
  logic signed [HEIGHT_W-1:0] level_h [MAX_LEVELS];
  logic signed [VALUE_W-1:0]  level_v [MAX_LEVELS];
  logic [COUNT_W-1:0]         level_count_q;

  interp_t pending_interp_q [$];
  int      fails;
  int      checked;

  // Bracket the target in the table and blend the two sample values.
  function automatic interp_t bracket_interpolate(logic signed [HEIGHT_W-1:0] target);
    int      n, last, up, lo, i;
    bit      found;
    longint  num, den, w, acc;
    interp_t r;
    if (level_count_q == 0)
      n = 1;
    else if (level_count_q > MAX_LEVELS)
      n = MAX_LEVELS;
    else
      n = int'(level_count_q);
    last = n - 1;
    up = last;
    lo = last;
    w = WEIGHT_ONE;
    r.clamped = 1'b1;
    // The test against the last level wins over the test against the first.
    if (target > level_h[last]) begin
      if (target >= level_h[0]) begin
        up = 0;
        lo = 0;
      end else begin
        // Lower is the first level strictly below the target, upper the one before.
        up = 0;
        found = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!found) begin
            if (level_h[i] < target) begin
              lo = i;
              found = 1'b1;
            end else begin
              up = i;
            end
          end
        end
        num = longint'(target) - longint'(level_h[lo]);
        den = longint'(level_h[up]) - longint'(level_h[lo]);
        if (num <= 0)
          w = 0;
        else if (den <= 0)
          w = WEIGHT_ONE;
        else
          w = (num * WEIGHT_ONE) / den;
        if (w > WEIGHT_ONE)
          w = WEIGHT_ONE;
        r.clamped = 1'b0;
      end
    end
    acc = w * longint'(level_v[up]) + (WEIGHT_ONE - w) * longint'(level_v[lo]);
    acc = acc >>> 16;
    r.upper = up[LEVEL_W-1:0];
    r.lower = lo[LEVEL_W-1:0];
    r.weight = w[WEIGHT_W-1:0];
    r.value = acc[VALUE_W-1:0];
    return r;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $error("Result field %s: expected %0d, actual %0d", field, want, got);
      fails++;
    end
  endtask

  // Track the register and the table, queue predictions, check result beats.
  always @(posedge clk) begin
    interp_t want;
    if (!rst_n) begin
      level_count_q = COUNT_RESET;
      pending_interp_q.delete();
    end else begin
      if (cfg_we)
        level_count_q = cfg_wdata;

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.op)
          OP_LOAD_HEIGHT: level_h[in_ch.entry_index] = in_ch.entry_height;
          OP_LOAD_VALUE:  level_v[in_ch.entry_index] = in_ch.entry_value;
          OP_QUERY:       pending_interp_q = {pending_interp_q,
                                              bracket_interpolate(in_ch.target_height)};
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (pending_interp_q.size() == 0) begin
          $error("Result beat arrived with no query waiting for it");
          fails++;
        end else begin
          want = pending_interp_q.pop_front();
          check_field("upper_level", want.upper, out_ch.upper_level);
          check_field("lower_level", want.lower, out_ch.lower_level);
          check_field("weight", want.weight, out_ch.weight);
          check_field("result_value", want.value, out_ch.result_value);
          check_field("clamped", want.clamped, out_ch.clamped);
          checked++;
        end
      end
    end
    failure_count   <= fails;
    pending_results <= pending_interp_q.size();
    results_checked <= checked;
  end

endmodule

FILE: test/level_bracket_interpolator_top_test.sv
// Testbench top of the level bracket interpolator: clock, reset, table loads,
// queries and level-count writes, with random idling on both channels.
// Depends on lbi_pkg, lbi_in_if, lbi_out_if, the block and its checker.
`timescale 1ns / 100ps

module level_bracket_interpolator_top_test;
  import lbi_pkg::*;

  localparam int LEVELS       = 256;
  localparam int GAP_MAX      = 19;
  localparam int DRAIN_CYCLES = LEVELS + 40;
  localparam int HOLD_CYCLES  = 1500;
  localparam int END_LIMIT    = 20000;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  lbi_in_if  in_ch ();
  lbi_out_if out_ch ();

  bit idle_on;
  bit pressure_on;
  int failures;
  int pending;
  int checked;

  // Stimulus-side view of the table, used to aim targets and avoid unwritten entries.
  logic signed [HEIGHT_W-1:0] shadow_h [LEVELS];
  bit                         h_loaded [LEVELS];
  bit                         v_loaded [LEVELS];
  int                         loads_sent;
  int                         queries_sent;
  int                         settings_used;

  level_bracket_interpolator_top #(.MAX_LEVELS(LEVELS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  level_bracket_interpolator_checker #(.MAX_LEVELS(LEVELS)) interp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .failure_count   (failures),
    .pending_results (pending),
    .results_checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("** level_bracket_interpolator_top: FAILED **");
    $finish;
  end

  function automatic logic signed [HEIGHT_W-1:0] clamp_height(int t);
    if (t > 8388607)
      t = 8388607;
    if (t < -8388608)
      t = -8388608;
    return t[HEIGHT_W-1:0];
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] rand_height();
    logic [31:0] r;
    r = $urandom;
    return r[HEIGHT_W-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_index();
    logic [31:0] r;
    r = $urandom;
    return r[ENTRY_W-1:0];
  endfunction

  // Sample values lean on the extremes, where the blend is most likely to overflow.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int active_levels(int cnt);
    if (cnt == 0)
      return 1;
    if (cnt > LEVELS)
      return LEVELS;
    return cnt;
  endfunction

  function automatic bit table_ready(int n);
    int i;
    for (i = 0; i < n; i++)
      if (!h_loaded[i] || !v_loaded[i])
        return 1'b0;
    return 1'b1;
  endfunction

  // Offer one beat, after a random gap when idling is on, and hold it until the block takes it.
  task automatic send_beat(logic [OP_W-1:0] op, logic [ENTRY_W-1:0] idx,
                           logic signed [HEIGHT_W-1:0] h, logic signed [VALUE_W-1:0] v,
                           logic signed [HEIGHT_W-1:0] t);
    int gap;
    gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op            = op;
    in_ch.entry_index   = idx;
    in_ch.entry_height  = h;
    in_ch.entry_value   = v;
    in_ch.target_height = t;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_QUERY)
      queries_sent++;
    else if (op != OP_UNUSED)
      loads_sent++;
  endtask

  task automatic load_height(int idx, int h);
    send_beat(OP_LOAD_HEIGHT, idx[ENTRY_W-1:0], clamp_height(h), rand_value(), rand_height());
    shadow_h[idx[ENTRY_W-1:0]] = clamp_height(h);
    h_loaded[idx[ENTRY_W-1:0]] = 1'b1;
  endtask

  task automatic load_value(int idx, logic signed [VALUE_W-1:0] v);
    send_beat(OP_LOAD_VALUE, idx[ENTRY_W-1:0], rand_height(), v, rand_height());
    v_loaded[idx[ENTRY_W-1:0]] = 1'b1;
  endtask

  task automatic query(int t);
    send_beat(OP_QUERY, rand_index(), rand_height(), rand_value(), clamp_height(t));
  endtask

  // Let every expected result arrive and any load or query in work finish.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_level_count(int cnt);
    settle_block();
    cfg_wdata = cnt[COUNT_W-1:0];
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    settings_used++;
  endtask

  // Write entries 0 to n-1: non-increasing heights with random spacing, or unsorted.
  task automatic fill_table(int n, bit sorted);
    int i, h, step_max, ht;
    step_max = ($urandom_range(0, 2) == 0) ? 3 : 16000000 / n;
    h = 8388607 - int'($urandom_range(0, 300000));
    for (i = 0; i < n; i++) begin
      ht = sorted ? h : int'(rand_height());
      if ($urandom_range(0, 1) == 0) begin
        load_height(i, ht);
        load_value(i, rand_value());
      end else begin
        load_value(i, rand_value());
        load_height(i, ht);
      end
      h = h - int'($urandom_range(0, step_max));
    end
  endtask

  // Aim at level heights, just beside them, between the ends, past the ends, at the extremes or at random.
  function automatic int pick_target(int n);
    int k, a, b, t;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 11))
      0, 1: t = shadow_h[k];
      2: t = shadow_h[k] + 1;
      3: t = shadow_h[k] - 1;
      4, 5, 6: begin
        a = shadow_h[n-1];
        b = shadow_h[0];
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        t = a + int'($urandom_range(0, b - a));
      end
      7: t = shadow_h[0] + int'($urandom_range(1, 1000));
      8: t = shadow_h[n-1] - int'($urandom_range(1, 1000));
      9: t = 8388607;
      10: t = -8388608;
      default: t = rand_height();
    endcase
    return t;
  endfunction

  // One level-count setting: write it, make the table readable, then mixed traffic.
  task automatic run_phase(int cnt, bit with_pressure);
    int n, j, per, r;
    write_level_count(cnt);
    n = active_levels(cnt);
    idle_on = ($urandom_range(0, 3) != 0);
    if (!table_ready(n) || (n <= 32 && $urandom_range(0, 2) != 0))
      fill_table(n, $urandom_range(0, 4) != 0);
    if (with_pressure)
      pressure_on = 1'b1;
    per = (n > 32) ? 25 : $urandom_range(20, 40);
    for (j = 0; j < per; j++) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        query(pick_target(n));
      else if (r < 85)
        load_height(rand_index(), rand_height());
      else if (r < 95)
        load_value(rand_index(), rand_value());
      else
        send_beat(OP_UNUSED, rand_index(), rand_height(), rand_value(), rand_height());
    end
  endtask

  // Result side: random stalls, one long hold-off, and stretches of steady ready.
  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (pressure_on && !held) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int plan [$];
    int phase, start_items, waited;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_LOAD_HEIGHT;
    in_ch.entry_index   = '0;
    in_ch.entry_height  = '0;
    in_ch.entry_value   = '0;
    in_ch.target_height = '0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    idle_on             = 1'b1;
    pressure_on         = 1'b0;
    rst_n               = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Three levels: two at the height extremes and one in the middle.
    write_level_count(3);
    load_height(0, 8388607);
    load_value(0, 32'h7FFF_FFFF);
    load_height(1, 50);
    load_value(1, 32'h8000_0000);
    load_height(2, -8388608);
    load_value(2, 12345);
    query(8388607);      // at the first level: clamped to it
    query(-8388608);     // at the last level: clamped to it
    query(50);           // exactly on an inner level: full weight, not clamped
    query(51);
    query(0);
    query(8388606);
    query(-8388607);
    query(49);
    send_beat(OP_UNUSED, rand_index(), rand_height(), rand_value(), rand_height());
    // A single level clamps everything; a count of zero acts as one.
    write_level_count(1);
    query(8388607);
    query(0);
    query(-8388608);
    write_level_count(0);
    query(100);

    // Random phases: the extremes of the level count first, then mostly small tables.
    plan = '{256, 511, 257, 1, 0, 2, 150};
    phase = 0;
    start_items = loads_sent + queries_sent;
    while (phase < plan.size() || (loads_sent + queries_sent - start_items) < RANDOM_ITEMS) begin
      if (phase < plan.size())
        run_phase(plan[phase], phase == 5);
      else if ($urandom_range(0, 7) == 0)
        run_phase($urandom_range(17, LEVELS - 1), 1'b0);
      else
        run_phase($urandom_range(2, 16), 1'b0);
      phase++;
    end

    // Drain and give the verdict.
    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < END_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending != 0)
      $error("%0d query results never arrived", pending);
    $display("Run covered %0d table loads and %0d queries over %0d level-count settings.",
             loads_sent, queries_sent, settings_used);
    $display("%0d interpolation results compared; result side held off once for %0d cycles.",
             checked, HOLD_CYCLES);
    if (failures == 0 && pending == 0)
      $display("** level_bracket_interpolator_top: PASSED **");
    else
      $display("** level_bracket_interpolator_top: FAILED **");
    $finish;
  end

endmodule
